### sv/spm_pkg.sv
`default_nettype none
package spm_pkg;
  localparam int MaxTerms  = 8;
  localparam int ProdDepth = MaxTerms * MaxTerms;
  localparam int TermIdxW  = $clog2(MaxTerms);
  localparam int TermCntW  = $clog2(MaxTerms + 1);
  localparam int ProdIdxW  = $clog2(ProdDepth);
  localparam int ProdCntW  = $clog2(ProdDepth + 1);
  localparam logic signed [39:0] CoefMax = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] CoefMin = -40'sh8000000000;

  typedef struct packed {
    logic               operand_b;
    logic signed [15:0] coef_in;
    logic        [9:0]  exp_in;
    logic               last_in;
  } spm_in_t;

  typedef struct packed {
    logic signed [39:0] coef_out;
    logic        [10:0] exp_out;
    logic               empty_out;
    logic               last_out;
  } spm_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // store the incoming term
    logic clr_terms;  // zero operand counts
    logic clr_prod;   // zero result count
    logic mul;        // form product of current pair
    logic srch_init;  // start search for registered product
    logic srch_step;  // compare one result entry
    logic emit_rd;    // read one result entry
    logic pair_next;  // advance pair indices
  } spm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic no_pairs;   // an operand is empty
    logic pair_last;  // current pair is the final one
    logic srch_done;  // search finished and table updated
    logic emit_end;   // no more entries to read
    logic emit_hit;   // registered entry is nonzero
  } spm_sts_t;
endpackage
`default_nettype wire

### sv/sparse_poly_mult_unit.sv
`default_nettype none
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | spm_in_t  (operand_b, coef_in, exp_in, last_in)
// out     | output    | out_valid_o / out_stall_i | spm_out_t (coef_out, exp_out, empty_out, last_out)
// Terms are taken while the controller is idle. After the last B term each of the up to
// 64 products is formed and a search started, each result entry being read (registered)
// and then compared; then the entries are read for output and each result is shown.
// Reset clears counts and the controller; tables need no clearing.
// A stalled result holds the block; no terms are taken until the product ends.
// Each result is taken from a payload register, so out_stall_i never reaches data.
module sparse_poly_mult_unit import spm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire spm_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output spm_out_t      out_data_o
);
  spm_cmd_t cmd;
  spm_sts_t sts;
  logic signed [39:0] rd_coef;
  logic        [10:0] rd_exp;
  logic               empty, last, load;
  logic signed [39:0] coef_q;
  logic        [10:0] exp_q;

  spm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .req_i(in_data_i), .in_stall_o,
    .out_valid_o, .out_stall_i, .out_empty_o(empty), .out_last_o(last),
    .out_load_o(load), .sts_i(sts), .cmd_o(cmd)
  );

  spm_datapath u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .rd_coef_o(rd_coef), .rd_exp_o(rd_exp)
  );

  // hold the latest nonzero entry for the output request
  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q <= rd_coef;
      exp_q  <= rd_exp;
    end
  end

  assign out_data_o.coef_out  = empty ? '0 : coef_q;
  assign out_data_o.exp_out   = empty ? '0 : exp_q;
  assign out_data_o.empty_out = empty;
  assign out_data_o.last_out  = last;
endmodule
`default_nettype wire

### sv/spm_datapath.sv
`default_nettype none
module spm_datapath import spm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire spm_in_t  req_i,
  input  wire spm_cmd_t cmd_i,
  output spm_sts_t      sts_o,
  output logic signed [39:0] rd_coef_o,
  output logic        [10:0] rd_exp_o
);
  logic signed [15:0] a_coef_q [MaxTerms];
  logic        [9:0]  a_exp_q  [MaxTerms];
  logic signed [15:0] b_coef_q [MaxTerms];
  logic        [9:0]  b_exp_q  [MaxTerms];
  logic [TermCntW-1:0] a_cnt_q, b_cnt_q;
  logic [TermIdxW-1:0] i_q, j_q;

  logic signed [39:0] pc_mem [ProdDepth];
  logic        [10:0] pe_mem [ProdDepth];
  logic [ProdCntW-1:0] p_cnt_q, k_q;

  logic signed [31:0] prod_q;
  logic        [10:0] pexp_q;
  logic               srch_busy_q, done_q;
  logic signed [39:0] pc_rd_q;
  logic        [10:0] pe_rd_q;
  logic [ProdIdxW-1:0] rd_idx_q;
  logic               rdv_q;
  logic signed [39:0] rd_coef_q;
  logic        [10:0] rd_exp_q;
  logic               rd_valid_q;

  logic [TermCntW-1:0] i_ext, j_ext;
  assign i_ext = TermCntW'(i_q);
  assign j_ext = TermCntW'(j_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (!req_i.operand_b && a_cnt_q < TermCntW'(MaxTerms)) begin
        a_coef_q[a_cnt_q[TermIdxW-1:0]] <= req_i.coef_in;
        a_exp_q[a_cnt_q[TermIdxW-1:0]]  <= req_i.exp_in;
      end
      if (req_i.operand_b && b_cnt_q < TermCntW'(MaxTerms)) begin
        b_coef_q[b_cnt_q[TermIdxW-1:0]] <= req_i.coef_in;
        b_exp_q[b_cnt_q[TermIdxW-1:0]]  <= req_i.exp_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else if (cmd_i.clr_terms) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        if (!req_i.operand_b && a_cnt_q < TermCntW'(MaxTerms)) a_cnt_q <= a_cnt_q + 1'b1;
        if (req_i.operand_b && b_cnt_q < TermCntW'(MaxTerms)) b_cnt_q <= b_cnt_q + 1'b1;
      end
      if (cmd_i.pair_next) begin
        if (j_ext + 1'b1 == b_cnt_q) begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 32'(a_coef_q[i_q] * b_coef_q[j_q]);
      pexp_q <= 11'(a_exp_q[i_q]) + 11'(b_exp_q[j_q]);
    end
  end

  // search: one registered entry read a cycle, compared the cycle after
  logic               match;
  logic signed [40:0] sum;
  logic signed [39:0] sat_sum, base;
  assign match = rdv_q && (pe_rd_q == pexp_q);
  assign base  = match ? pc_rd_q : '0;
  assign sum   = 41'(base) + 41'(prod_q);
  always_comb begin
    if (sum > 41'(CoefMax))      sat_sum = CoefMax;
    else if (sum < 41'(CoefMin)) sat_sum = CoefMin;
    else                         sat_sum = sum[39:0];
  end

  logic scan_end;
  assign scan_end = (k_q == p_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_cnt_q     <= '0;
      k_q         <= '0;
      rdv_q       <= 1'b0;
      srch_busy_q <= 1'b0;
      done_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.clr_prod) begin
        p_cnt_q    <= '0;
        k_q        <= '0;
        rd_valid_q <= 1'b0;
      end
      if (cmd_i.srch_init) begin
        k_q         <= '0;
        rdv_q       <= 1'b0;
        srch_busy_q <= 1'b1;
      end else if (cmd_i.srch_step && srch_busy_q) begin
        if (match || scan_end) begin
          srch_busy_q <= 1'b0;
          done_q      <= 1'b1;
          k_q         <= '0;
          rdv_q       <= 1'b0;
          if (!match && p_cnt_q != ProdCntW'(ProdDepth)) p_cnt_q <= p_cnt_q + 1'b1;
        end else begin
          rdv_q <= 1'b1;
          k_q   <= k_q + 1'b1;
        end
      end
      if (cmd_i.emit_rd) begin
        rd_valid_q <= !scan_end;
        if (!scan_end) k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_step && srch_busy_q) begin
      if (match) begin
        pc_mem[rd_idx_q] <= sat_sum;
      end else if (scan_end) begin
        if (p_cnt_q != ProdCntW'(ProdDepth)) begin
          pc_mem[p_cnt_q[ProdIdxW-1:0]] <= sat_sum;
          pe_mem[p_cnt_q[ProdIdxW-1:0]] <= pexp_q;
        end
      end else begin
        pc_rd_q  <= pc_mem[k_q[ProdIdxW-1:0]];
        pe_rd_q  <= pe_mem[k_q[ProdIdxW-1:0]];
        rd_idx_q <= k_q[ProdIdxW-1:0];
      end
    end
    if (cmd_i.emit_rd && !scan_end) begin
      rd_coef_q <= pc_mem[k_q[ProdIdxW-1:0]];
      rd_exp_q  <= pe_mem[k_q[ProdIdxW-1:0]];
    end
  end

  assign rd_coef_o = rd_coef_q;
  assign rd_exp_o  = rd_exp_q;

  assign sts_o.no_pairs  = (a_cnt_q == '0) || (b_cnt_q == '0);
  assign sts_o.pair_last = (i_ext + 1'b1 == a_cnt_q) && (j_ext + 1'b1 == b_cnt_q);
  assign sts_o.srch_done = done_q;
  assign sts_o.emit_end  = scan_end;
  assign sts_o.emit_hit  = rd_valid_q && (rd_coef_q != '0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_cnt_q <= ProdCntW'(ProdDepth)) else $error("result count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !srch_busy_q) else $error("search done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_init |=> srch_busy_q) else $error("search did not start");
endmodule
`default_nettype wire

### sv/spm_ctrl.sv
`default_nettype none
module spm_ctrl import spm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire spm_in_t  req_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output logic          out_empty_o,
  output logic          out_last_o,
  output logic          out_load_o,
  input  wire spm_sts_t sts_i,
  output spm_cmd_t      cmd_o
);
  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StMul  = 7'b0000010,
    StInit = 7'b0000100,
    StSrch = 7'b0001000,
    StRd   = 7'b0010000,
    StChk  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   held_q, held_d, fin_q, fin_d;
  logic   accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // hold each nonzero entry until the next one or the end is found, so the
  // final one can carry last
  always_comb begin
    state_d    = state_q;
    held_d     = held_q;
    fin_d      = fin_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.load = accept;
        if (accept && req_i.operand_b && req_i.last_in) begin
          cmd_o.clr_prod = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        held_d = 1'b0;
        fin_d  = 1'b0;
        if (sts_i.no_pairs) begin
          state_d = StRd;
        end else begin
          cmd_o.mul = 1'b1;
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.srch_init = 1'b1;
        state_d = StSrch;
      end
      StSrch: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          if (sts_i.pair_last) begin
            cmd_o.emit_rd = 1'b1;
            state_d = StChk;
          end else begin
            cmd_o.pair_next = 1'b1;
            state_d = StMul;
          end
        end
      end
      StRd: begin
        cmd_o.emit_rd = 1'b1;
        state_d = StChk;
      end
      StChk: begin
        if (sts_i.emit_hit) begin
          if (held_q) begin
            state_d = StOut;
          end else begin
            out_load_o    = 1'b1;
            held_d        = 1'b1;
            cmd_o.emit_rd = 1'b1;
          end
        end else if (sts_i.emit_end) begin
          fin_d   = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.emit_rd = 1'b1;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          if (fin_q) begin
            cmd_o.clr_terms = 1'b1;
            state_d = StIdle;
          end else begin
            out_load_o    = 1'b1;
            cmd_o.emit_rd = 1'b1;
            state_d = StChk;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = (state_q == StOut);
  assign out_empty_o = fin_q && !held_q;
  assign out_last_o  = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      held_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      fin_q   <= fin_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_empty_o && out_valid_o |-> out_last_o) else $error("empty not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fin_q |-> held_q) else $error("result shown without entry");
endmodule
`default_nettype wire
